// File: design/mbf_pkg.sv
package mbf_pkg;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned CoefW    = 24;
  localparam int unsigned ChannelW = 3;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic [ChannelW-1:0]       channel_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  typedef enum logic {
    MODE_FILTER = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_reg_e;

  // Q4.20 unity gain
  localparam coef_t COEF_B0_RESET = 24'sd1048576;

  localparam int signed SampleMax = 8388607;
  localparam int signed SampleMin = -8388608;

endpackage

// File: design/mbf_if.sv
interface mbf_in_if;
  logic               valid;
  logic               ready;
  mbf_pkg::mode_e     mode;
  mbf_pkg::channel_t  channel;
  mbf_pkg::sample_t   sample_in;

  modport source (output valid, output mode, output channel, output sample_in, input ready);
  modport sink   (input valid, input mode, input channel, input sample_in, output ready);
endinterface

interface mbf_out_if;
  logic               valid;
  logic               ready;
  mbf_pkg::channel_t  channel_out;
  mbf_pkg::sample_t   sample_out;
  logic               saturated;

  modport source (output valid, output channel_out, output sample_out, output saturated,
                  input ready);
  modport sink   (input valid, input channel_out, input sample_out, input saturated,
                  output ready);
endinterface

interface mbf_cfg_if;
  logic               valid;
  logic               ready;
  mbf_pkg::cfg_idx_t  index;
  mbf_pkg::coef_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/multichannel_biquad_filter.sv
// Flow: a request accepted into the input register moves on to the result register once that is free,
//   and its result shows on out_o from there. Throughput: one request per cycle, same channel back to
//   back included, while the output is not stalled; a clear or unused-channel request gives no result.
// Reset (rst_ni low, asynchronous): coefficients return to b0 = 1.0 and the rest zero, all
//   channel histories clear, both pipeline registers empty.
module multichannel_biquad_filter #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbf_in_if.sink     in_i,
  mbf_cfg_if.sink    cfg_i,
  mbf_out_if.source  out_o
);
  import mbf_pkg::*;

  localparam int unsigned IdxW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned ProdW = SampleW + CoefW;
  // five products of 48 bits each need three guard bits
  localparam int unsigned AccW  = ProdW + 3;
  localparam int unsigned FracShift = 20;

  localparam logic signed [AccW-1:0] RoundBias = AccW'(1 << (FracShift - 1));
  localparam logic signed [AccW-1:0] SatHi     = AccW'(SampleMax);
  localparam logic signed [AccW-1:0] SatLo     = AccW'(SampleMin);

  // ------------------------------------------------------------------
  // Coefficient registers: always ready, out-of-list indexes drop.
  // ------------------------------------------------------------------
  coef_t b0_q, b1_q, b2_q, a1_q, a2_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_B0_RESET;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_B0:  b0_q <= cfg_i.data;
        CFG_B1:  b1_q <= cfg_i.data;
        CFG_B2:  b2_q <= cfg_i.data;
        CFG_A1:  a1_q <= cfg_i.data;
        CFG_A2:  a2_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Input register: holds one request while the filter works on it.
  // ------------------------------------------------------------------
  logic     s1_valid_q;
  mode_e    s1_mode_q;
  channel_t s1_chan_q;
  sample_t  s1_x_q;

  logic s1_in_range;
  logic s1_has_res;
  logic out_free;
  logic s1_adv;
  logic in_fire;

  // a filter request for a channel at or above NUM_CHANNELS is dropped silently
  assign s1_in_range = (32'(s1_chan_q) < NUM_CHANNELS);
  assign s1_has_res  = (s1_mode_q == MODE_FILTER) && s1_in_range;
  assign out_free    = !out_o.valid || out_o.ready;
  // advance when the result has somewhere to go, or when there is no result
  assign s1_adv      = s1_valid_q && (!s1_has_res || out_free);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q <= in_i.mode;
      s1_chan_q <= in_i.channel;
      s1_x_q    <= in_i.sample_in;
    end
  end

  // ------------------------------------------------------------------
  // Per-channel histories. Flip-flops, so a clear request wipes every
  // channel at once.
  // ------------------------------------------------------------------
  sample_t x1_q [NUM_CHANNELS];
  sample_t x2_q [NUM_CHANNELS];
  sample_t y1_q [NUM_CHANNELS];
  sample_t y2_q [NUM_CHANNELS];

  logic [IdxW-1:0] s1_idx;
  assign s1_idx = IdxW'(s1_chan_q);

  sample_t x1, x2, y1, y2;
  assign x1 = x1_q[s1_idx];
  assign x2 = x2_q[s1_idx];
  assign y1 = y1_q[s1_idx];
  assign y2 = y2_q[s1_idx];

  // ------------------------------------------------------------------
  // Direct form I sum: five products, then round half up and clip.
  // ------------------------------------------------------------------
  logic signed [ProdW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  rounded;
  logic                    sat_hi, sat_lo;
  sample_t                 y_d;
  logic                    sat_d;

  assign p_b0 = b0_q * s1_x_q;
  assign p_b1 = b1_q * x1;
  assign p_b2 = b2_q * x2;
  assign p_a1 = a1_q * y1;
  assign p_a2 = a2_q * y2;

  assign acc = AccW'(p_b0) + AccW'(p_b1) + AccW'(p_b2) - AccW'(p_a1) - AccW'(p_a2);

  // arithmetic shift gives the floor, so the bias makes it round half up
  assign rounded = (acc + RoundBias) >>> FracShift;
  assign sat_hi  = (rounded > SatHi);
  assign sat_lo  = (rounded < SatLo);
  assign sat_d   = sat_hi || sat_lo;

  always_comb begin
    if (sat_hi) begin
      y_d = sample_t'(SampleMax);
    end else if (sat_lo) begin
      y_d = sample_t'(SampleMin);
    end else begin
      y_d = rounded[SampleW-1:0];
    end
  end

  // shift the histories of the channel served; the clipped value is fed back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_mode_q == MODE_CLEAR) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          x1_q[i] <= '0;
          x2_q[i] <= '0;
          y1_q[i] <= '0;
          y2_q[i] <= '0;
        end
      end else if (s1_in_range) begin
        x2_q[s1_idx] <= x1;
        x1_q[s1_idx] <= s1_x_q;
        y2_q[s1_idx] <= y1;
        y1_q[s1_idx] <= y_d;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result register: parts the filter from a stalled consumer.
  // ------------------------------------------------------------------
  logic     out_valid_q;
  channel_t out_chan_q;
  sample_t  out_y_q;
  logic     out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_res) begin
      out_chan_q <= s1_chan_q;
      out_y_q    <= y_d;
      out_sat_q  <= sat_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_chan_q;
  assign out_o.sample_out  = out_y_q;
  assign out_o.saturated   = out_sat_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_has_res |=> out_valid_q)
    else $error("filtered request did not reach the result register");

  a_sat_is_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sat_q |->
      (out_y_q == sample_t'(SampleMax)) || (out_y_q == sample_t'(SampleMin)))
    else $error("saturated result is not at a rail");

  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && s1_has_res && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked result");

  a_clear_wipes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_mode_q == MODE_CLEAR) |=> (y1_q[0] == '0) && (x1_q[0] == '0))
    else $error("clear request left history behind");

endmodule

// File: verif/tb_multichannel_biquad_filter.sv
`timescale 1ns / 1ps

module tb_multichannel_biquad_filter;
  import mbf_pkg::*;

  localparam int unsigned NUM_CH      = 8;
  localparam int unsigned IDLE_PAUSE  = 3;       // cycles to let a clear request retire
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_REQS  = 100;

  // Q4.20 rounding: add half an LSB of the result, then drop 20 fraction bits
  localparam int         FRAC_DROP  = 20;
  localparam longint     ROUND_HALF = 64'sd1 <<< (FRAC_DROP - 1);

  localparam cfg_idx_t FIRST_UNUSED_IDX = cfg_idx_t'(CFG_A2) + cfg_idx_t'(1);
  localparam cfg_idx_t LAST_IDX         = '1;

  // one filtered sample as it leaves the block
  typedef struct packed {
    channel_t ch;
    sample_t  smp;
    logic     sat;
  } filtered_t;

  typedef struct packed {
    cfg_idx_t idx;
    coef_t    val;
  } reg_write_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_REG_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    mode_e     mode;
    channel_t  ch;
    sample_t   smp;
    cfg_idx_t  idx;
    coef_t     val;
    bit        known;    // expected result typed into the table
    sample_t   known_smp;
    bit        known_sat;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mbf_in_if  in_if ();
  mbf_out_if out_if ();
  mbf_cfg_if cfg_if ();

  // Typed-in expectation travelling alongside the request it belongs to.
  logic    known_valid;
  sample_t known_smp;
  logic    known_sat;

  multichannel_biquad_filter #(
    .NUM_CHANNELS (NUM_CH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the filter: coefficients and per-channel delay lines
  // ---------------------------------------------------------------------------
  coef_t   tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
  sample_t x_d1 [NUM_CH];
  sample_t x_d2 [NUM_CH];
  sample_t y_d1 [NUM_CH];
  sample_t y_d2 [NUM_CH];

  filtered_t  expected_filtered [$];
  reg_write_t pending_writes [$];
  stim_row_t  directed_rows [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          burst_mode;

  function automatic void wipe_history();
    foreach (x_d1[c]) begin
      x_d1[c] = '0;
      x_d2[c] = '0;
      y_d1[c] = '0;
      y_d2[c] = '0;
    end
  endfunction

  // Run one sample through the biquad of its channel and shift the delay lines.
  function automatic filtered_t filter_sample(channel_t ch, sample_t smp);
    longint    acc;
    longint    rounded;
    filtered_t res;
    acc = longint'(tap_b0) * longint'(smp)
        + longint'(tap_b1) * longint'(x_d1[ch])
        + longint'(tap_b2) * longint'(x_d2[ch])
        - longint'(tap_a1) * longint'(y_d1[ch])
        - longint'(tap_a2) * longint'(y_d2[ch]);
    rounded = (acc + ROUND_HALF) >>> FRAC_DROP;
    res.sat = 1'b0;
    if (rounded > SampleMax) begin
      rounded = SampleMax;
      res.sat = 1'b1;
    end else if (rounded < SampleMin) begin
      rounded = SampleMin;
      res.sat = 1'b1;
    end
    res.ch  = ch;
    res.smp = sample_t'(rounded);
    // the clipped value is what feeds back
    x_d2[ch] = x_d1[ch];
    x_d1[ch] = smp;
    y_d2[ch] = y_d1[ch];
    y_d1[ch] = res.smp;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake on the edge, before any update lands.
  // Results are checked before new expectations are queued, so an output can
  // never be matched against the request accepted on the same edge.
  // ---------------------------------------------------------------------------
  filtered_t want;
  filtered_t fresh;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_B0:  tap_b0 = cfg_if.data;
          CFG_B1:  tap_b1 = cfg_if.data;
          CFG_B2:  tap_b2 = cfg_if.data;
          CFG_A1:  tap_a1 = cfg_if.data;
          CFG_A2:  tap_a2 = cfg_if.data;
          default: ;  // unused index: drop the write
        endcase
      end

      if (out_if.valid && out_if.ready) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: unexpected result: expected none, got channel %0d sample %0d sat %0b",
                   $time, out_if.channel_out, $signed(out_if.sample_out), out_if.saturated);
          mismatch_count++;
        end else begin
          want = expected_filtered.pop_front();
          if (out_if.channel_out !== want.ch) begin
            $display("%0t: channel_out: expected %0d, got %0d",
                     $time, want.ch, out_if.channel_out);
            mismatch_count++;
          end
          if (out_if.sample_out !== want.smp) begin
            $display("%0t: sample_out (ch %0d): expected %0d, got %0d",
                     $time, want.ch, $signed(want.smp), $signed(out_if.sample_out));
            mismatch_count++;
          end
          if (out_if.saturated !== want.sat) begin
            $display("%0t: saturated (ch %0d): expected %0b, got %0b",
                     $time, want.ch, want.sat, out_if.saturated);
            mismatch_count++;
          end
        end
      end

      if (in_if.valid && in_if.ready) begin
        if (in_if.mode == MODE_CLEAR) begin
          wipe_history();
        end else begin
          fresh = filter_sample(in_if.channel, in_if.sample_in);
          // a typed-in row overrides the computed sample; history still advances
          if (known_valid) begin
            fresh.smp = known_smp;
            fresh.sat = known_sat;
          end
          expected_filtered.push_back(fresh);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure: short stalls mostly, a few long ones, and now and
  // then a long stretch with ready held high.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned run;
    logic        level;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        level = 1'b1;
        run   = $urandom_range(30, 150);
      end else if (pick < 60) begin
        level = 1'b1;
        run   = $urandom_range(1, 4);
      end else if (pick < 92) begin
        level = 1'b0;
        run   = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        run   = $urandom_range(10, 40);
      end
      out_if.ready <= level;
      repeat (run) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (burst_mode) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return sample_t'(SampleMax);
          1:       return sample_t'(SampleMin);
          2:       return '0;
          3:       return sample_t'(1);
          default: return sample_t'(-1);
        endcase
      end
      1, 2, 3: return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // style 0: corner values, 1: within +/-1.0, 2: anything in the field
  function automatic coef_t pick_coef(int unsigned style);
    if (style == 0) begin
      case ($urandom_range(0, 4))
        0:       return coef_t'(SampleMax);
        1:       return coef_t'(SampleMin);
        2:       return '0;
        3:       return COEF_B0_RESET;
        default: return coef_t'(-1);
      endcase
    end
    if (style == 1) return coef_t'(int'($urandom_range(0, 2097152)) - 1048576);
    return coef_t'($urandom());
  endfunction

  // Offer one request; hold it until taken, then maybe idle for a while.
  task automatic issue_request(mode_e m, channel_t ch, sample_t smp,
                               bit known, sample_t k_smp, bit k_sat);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.mode      <= m;
    in_if.channel   <= ch;
    in_if.sample_in <= smp;
    known_valid     <= known;
    known_smp       <= k_smp;
    known_sat       <= k_sat;
    do @(posedge clk_i); while (!in_if.ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, let the monitor log the last request, drain every expected
  // result, then let a trailing clear retire.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_filtered.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  // Write the staged registers back to back while the filter is quiet.
  task automatic flush_reg_writes();
    wait_idle();
    foreach (pending_writes[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= pending_writes[i].idx;
      cfg_if.data  <= pending_writes[i].val;
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    pending_writes.delete();
  endtask

  function automatic void add_req(mode_e m, int ch, int smp, bit known, int k_smp, bit k_sat);
    stim_row_t row;
    row.kind      = ROW_REQUEST;
    row.mode      = m;
    row.ch        = channel_t'(ch);
    row.smp       = sample_t'(smp);
    row.idx       = CFG_B0;
    row.val       = '0;
    row.known     = known;
    row.known_smp = sample_t'(k_smp);
    row.known_sat = k_sat;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_t idx, int val);
    stim_row_t row;
    row.kind      = ROW_REG_WRITE;
    row.mode      = MODE_FILTER;
    row.ch        = '0;
    row.smp       = '0;
    row.idx       = idx;
    row.val       = coef_t'(val);
    row.known     = 1'b0;
    row.known_smp = '0;
    row.known_sat = 1'b0;
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    channel_t    hot_ch;
    int unsigned style;

    // Known values everywhere before the first edge; shadow state as after reset.
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_FILTER;
    in_if.channel   <= '0;
    in_if.sample_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_B0;
    cfg_if.data     <= '0;
    known_valid     <= 1'b0;
    known_smp       <= '0;
    known_sat       <= 1'b0;
    tap_b0          = COEF_B0_RESET;
    tap_b1          = '0;
    tap_b2          = '0;
    tap_a1          = '0;
    tap_a2          = '0;
    wipe_history();
    mismatch_count  = 0;
    cycle_count     = 0;
    burst_mode      = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. With b0 = 1.0 and the other taps at zero the output is
    // the input; with b0 = one LSB the rounding boundary shows directly.
    //      mode         ch  sample      known  result     sat
    add_req(MODE_FILTER, 0,  0,          1,     0,         0);
    add_req(MODE_FILTER, 1,  8388607,    1,     8388607,   0);
    add_req(MODE_FILTER, 7,  -8388608,   1,     -8388608,  0);
    add_req(MODE_FILTER, 2,  -1,         1,     -1,        0);
    add_req(MODE_CLEAR,  5,  -8388608,   0,     0,         0);
    add_cfg(CFG_B0, 1);
    add_req(MODE_FILTER, 3,  524288,     1,     1,         0);  // exactly half: rounds up
    add_req(MODE_FILTER, 3,  524287,     1,     0,         0);
    add_req(MODE_FILTER, 4,  -524288,    1,     0,         0);  // minus half: rounds up to 0
    add_req(MODE_FILTER, 4,  -524289,    1,     -1,        0);
    add_cfg(CFG_B0, 8388607);
    add_req(MODE_FILTER, 5,  8388607,    1,     8388607,   1);  // clip high
    add_req(MODE_FILTER, 6,  -8388608,   1,     -8388608,  1);  // clip low
    add_cfg(CFG_B0, -8388608);
    add_req(MODE_FILTER, 6,  -8388608,   1,     8388607,   1);
    add_req(MODE_FILTER, 0,  8388607,    1,     -8388608,  1);
    // Full biquad on one channel, then a clear in the middle of its history.
    add_cfg(CFG_B0, 1048576);
    add_cfg(CFG_B1, 1048576);
    add_cfg(CFG_B2, -1048576);
    add_cfg(CFG_A1, 524288);
    add_cfg(CFG_A2, -262144);
    add_req(MODE_FILTER, 1,  1000000,    0,     0,         0);
    add_req(MODE_FILTER, 1,  -3000000,   0,     0,         0);
    add_req(MODE_FILTER, 1,  8388607,    0,     0,         0);
    add_req(MODE_FILTER, 1,  0,          0,     0,         0);
    add_req(MODE_CLEAR,  6,  8388607,    0,     0,         0);
    add_req(MODE_FILTER, 1,  500000,     0,     0,         0);
    // Extreme feed-forward and feedback taps: saturation fed back.
    add_cfg(CFG_B1, 8388607);
    add_cfg(CFG_B2, -8388608);
    add_cfg(CFG_A1, -8388608);
    add_cfg(CFG_A2, 8388607);
    add_req(MODE_FILTER, 2,  8388607,    0,     0,         0);
    add_req(MODE_FILTER, 2,  -8388608,   0,     0,         0);
    add_req(MODE_FILTER, 2,  8388607,    0,     0,         0);
    add_req(MODE_FILTER, 2,  1,          0,     0,         0);
    // Writes to unused indexes must leave every tap alone.
    add_cfg(FIRST_UNUSED_IDX, 8388607);
    add_cfg(LAST_IDX, -8388608);
    add_req(MODE_FILTER, 2,  -1,         0,     0,         0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG_WRITE) begin
        pending_writes.push_back('{directed_rows[i].idx, directed_rows[i].val});
      end else begin
        if (pending_writes.size() != 0) flush_reg_writes();
        issue_request(directed_rows[i].mode, directed_rows[i].ch, directed_rows[i].smp,
                      directed_rows[i].known, directed_rows[i].known_smp,
                      directed_rows[i].known_sat);
      end
    end

    // Random phases: new values for some or all taps each time, requests with random content.
    // Every fourth phase runs without input gaps.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      style      = ph % 3;
      burst_mode = (ph % 4 == 3);
      if (ph == 0 || $urandom_range(0, 4) != 0) pending_writes.push_back('{CFG_B0, pick_coef(style)});
      if (ph == 0 || $urandom_range(0, 4) != 0) pending_writes.push_back('{CFG_B1, pick_coef(style)});
      if (ph == 0 || $urandom_range(0, 4) != 0) pending_writes.push_back('{CFG_B2, pick_coef(style)});
      if (ph == 0 || $urandom_range(0, 4) != 0) pending_writes.push_back('{CFG_A1, pick_coef(style)});
      if (ph == 0 || $urandom_range(0, 4) != 0) pending_writes.push_back('{CFG_A2, pick_coef(style)});
      if ($urandom_range(0, 1) != 0)
        pending_writes.push_back('{cfg_idx_t'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)),
                                   coef_t'($urandom())});
      flush_reg_writes();

      hot_ch = channel_t'($urandom());
      for (int unsigned n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 99) < 4) begin
          issue_request(MODE_CLEAR, channel_t'($urandom()), sample_t'($urandom()), 0, '0, 0);
        end else begin
          // lean on one channel so its history builds up back to back
          if ($urandom_range(0, 9) < 4)
            issue_request(MODE_FILTER, hot_ch, pick_sample(), 0, '0, 0);
          else
            issue_request(MODE_FILTER, channel_t'($urandom()), pick_sample(), 0, '0, 0);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
